// ===== rtl/ats_pkg.sv =====
// Shared constants and types for the array tree shape checker.
`timescale 1ns / 1ps

package ats_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = IDX_W;
    localparam int LVL_W       = $clog2(IDX_W + 2);
    localparam int VAL_W       = 32;
    localparam int OUT_CNT_W   = 11;
    localparam int OUT_H_W     = 4;

    localparam logic [IDX_W-1:0] MAX_IDX   = IDX_W'(MAX_ENTRIES);
    localparam logic [VAL_W-1:0] EMPTY_VAL = '1;

    typedef struct packed {
        logic              take;
        logic [IDX_W-1:0]  idx;
        logic [LVL_W-1:0]  lvl;
        logic              here;
        logic              last;
    } t_item;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              here;
        logic              reach;
    } t_map_wr;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] node_count;
        logic [OUT_H_W-1:0]   tree_height;
        logic [OUT_CNT_W-1:0] leaf_count;
        logic                 is_valid;
        logic                 is_perfect;
        logic                 overflow;
    } t_result;

endpackage

// ===== rtl/ats_map_mem.sv =====
// Present/reach bit map: one write port, one registered read port with bypass.
`timescale 1ns / 1ps

module ats_map_mem (
    input  logic                       i_clk,
    input  ats_pkg::t_map_wr           i_wr,
    input  logic                       i_rd_en,
    input  logic [ats_pkg::ADDR_W-1:0] i_rd_addr,
    output logic                       o_par_here,
    output logic                       o_par_reach
);

    logic [1:0] r_mem [ats_pkg::MAX_ENTRIES];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= {i_wr.here, i_wr.reach};
        end
        if (i_rd_en) begin
            if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
                r_rdata <= {i_wr.here, i_wr.reach};
            end else begin
                r_rdata <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_par_here  = r_rdata[1];
    assign o_par_reach = r_rdata[0];

endmodule

// ===== rtl/ats_tally.sv =====
// Per-array accumulators, map write-back and final metric computation.
`timescale 1ns / 1ps

module ats_tally (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_commit,
    input  ats_pkg::t_item    i_item,
    input  logic              i_par_here,
    input  logic              i_par_reach,
    output ats_pkg::t_map_wr  o_wr,
    output logic              o_done,
    output ats_pkg::t_result  o_res
);

    logic [ats_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [ats_pkg::CNT_W-1:0] r_inner, n_inner;
    logic [ats_pkg::LVL_W-1:0] r_deep, n_deep;
    logic                      r_ok, n_ok;
    logic                      r_lcp, n_lcp;
    logic                      r_lpar, n_lpar;
    logic                      r_ovf, n_ovf;
    logic                      w_root;
    logic                      w_reach;
    logic [ats_pkg::CNT_W-1:0] w_inner_fin;
    logic [ats_pkg::CNT_W:0]   w_full;

    assign w_root  = (i_item.idx == '0);
    assign w_reach = i_item.here && (w_root || i_par_reach);

    always_comb begin
        n_cnt   = r_cnt;
        n_inner = r_inner;
        n_deep  = r_deep;
        n_ok    = r_ok;
        n_lcp   = r_lcp;
        n_lpar  = r_lpar;
        n_ovf   = r_ovf;
        if (i_item.take) begin
            if (w_reach && (i_item.lvl > r_deep)) begin
                n_deep = i_item.lvl;
            end
            if (i_item.here) begin
                n_cnt = r_cnt + 1'b1;
            end
            if (w_root) begin
                if (!i_item.here) begin
                    n_ok = 1'b0;
                end
            end else begin
                if (i_item.here && !i_par_here) begin
                    n_ok = 1'b0;
                end
                if (i_item.idx[0]) begin
                    n_lcp  = i_item.here;
                    n_lpar = i_par_here;
                end else begin
                    if ((r_lcp || i_item.here) && i_par_here) begin
                        n_inner = r_inner + 1'b1;
                    end
                    n_lcp = 1'b0;
                end
            end
        end else begin
            n_ovf = 1'b1;
        end
    end

    // a trailing left child closes its parent's pair
    assign w_inner_fin = n_inner + ats_pkg::CNT_W'(n_lcp && n_lpar);
    assign w_full      = (ats_pkg::CNT_W+1)'(1) << n_deep;

    always_comb begin
        o_res.node_count  = ats_pkg::OUT_CNT_W'(n_cnt);
        o_res.tree_height = ats_pkg::OUT_H_W'(n_deep);
        o_res.leaf_count  = ats_pkg::OUT_CNT_W'(n_cnt - w_inner_fin);
        o_res.is_valid    = n_ok;
        o_res.is_perfect  = (n_deep != '0) && ({1'b0, n_cnt} == (w_full - 1'b1));
        o_res.overflow    = n_ovf;
    end

    assign o_done     = i_commit && i_item.last;
    assign o_wr.en    = i_commit && i_item.take;
    assign o_wr.addr  = ats_pkg::ADDR_W'(i_item.idx);
    assign o_wr.here  = i_item.here;
    assign o_wr.reach = w_reach;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_done) begin
            r_cnt   <= '0;
            r_inner <= '0;
            r_deep  <= '0;
            r_ok    <= 1'b1;
            r_lcp   <= 1'b0;
            r_lpar  <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_commit) begin
            r_cnt   <= n_cnt;
            r_inner <= n_inner;
            r_deep  <= n_deep;
            r_ok    <= n_ok;
            r_lcp   <= n_lcp;
            r_lpar  <= n_lpar;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ===== rtl/array_tree_shape_checker.sv =====
// Array tree shape checker: beat staging, index tracking and result register.
// The parent map read is issued at accept; results load on last-beat commit.
// Throughput: one entry beat per cycle unless a last beat waits on a held result.
// The output register lets the next array start while a result waits.
// Reset clears counters and handshake state; the map memory is not cleared.
`timescale 1ns / 1ps

module array_tree_shape_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [31:0]        i_entry_value,
    input  logic                      i_last_entry,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [10:0]               o_node_count,
    output logic [3:0]                o_tree_height,
    output logic [10:0]               o_leaf_count,
    output logic                      o_is_valid,
    output logic                      o_is_perfect,
    output logic                      o_overflow
);

    logic [ats_pkg::IDX_W-1:0]  r_next_idx;
    logic [ats_pkg::LVL_W-1:0]  r_next_lvl;
    logic                       r_s1_valid;
    ats_pkg::t_item             r_s1;
    logic                       r_out_valid;
    ats_pkg::t_result           r_out;
    logic                       w_in_acc;
    logic                       w_s1_adv;
    logic                       w_take;
    logic [ats_pkg::IDX_W:0]    w_nx;
    logic                       w_new_lvl;
    logic [ats_pkg::IDX_W-1:0]  w_par_idx;
    logic                       w_par_here;
    logic                       w_par_reach;
    logic                       w_done;
    ats_pkg::t_map_wr           w_wr;
    ats_pkg::t_result           w_res;

    assign w_s1_adv  = r_s1_valid && (!r_s1.last || !r_out_valid || i_ready);
    assign o_ready   = !r_s1_valid || w_s1_adv;
    assign w_in_acc  = i_valid && o_ready;
    assign w_take    = r_next_idx < ats_pkg::MAX_IDX;
    assign w_nx      = {1'b0, r_next_idx} + (ats_pkg::IDX_W+1)'(2);
    assign w_new_lvl = ((w_nx & (w_nx - 1'b1)) == '0);
    assign w_par_idx = (r_next_idx - 1'b1) >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_idx <= '0;
            r_next_lvl <= ats_pkg::LVL_W'(1);
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
            if (i_last_entry) begin
                r_next_idx <= '0;
                r_next_lvl <= ats_pkg::LVL_W'(1);
            end else if (w_take) begin
                r_next_idx <= r_next_idx + 1'b1;
                r_next_lvl <= r_next_lvl + ats_pkg::LVL_W'(w_new_lvl);
            end
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1.take <= w_take;
            r_s1.idx  <= r_next_idx;
            r_s1.lvl  <= r_next_lvl;
            r_s1.here <= (i_entry_value != ats_pkg::EMPTY_VAL);
            r_s1.last <= i_last_entry;
        end
    end

    ats_map_mem u_map (
        .i_clk       (i_clk),
        .i_wr        (w_wr),
        .i_rd_en     (w_in_acc),
        .i_rd_addr   (ats_pkg::ADDR_W'(w_par_idx)),
        .o_par_here  (w_par_here),
        .o_par_reach (w_par_reach)
    );

    ats_tally u_tally (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (w_s1_adv),
        .i_item      (r_s1),
        .i_par_here  (w_par_here),
        .i_par_reach (w_par_reach),
        .o_wr        (w_wr),
        .o_done      (w_done),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_node_count  = r_out.node_count;
    assign o_tree_height = r_out.tree_height;
    assign o_leaf_count  = r_out.leaf_count;
    assign o_is_valid    = r_out.is_valid;
    assign o_is_perfect  = r_out.is_perfect;
    assign o_overflow    = r_out.overflow;

    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last_entry) |=> (r_next_idx == '0))
        else $error("entry index not restarted after last beat");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_idx <= ats_pkg::MAX_IDX)
        else $error("entry index past depth");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_done)
        else $error("result overwritten while stalled");

    a_perfect_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_perfect) |-> (o_tree_height != '0))
        else $error("perfect flag with zero height");

endmodule
